@@ rtl/tse_pkg.sv @@
// shared constants and types for the ternary search engine
package tse_pkg;

    // default sizing of the store
    localparam int TSE_STORE_DEPTH = 1024;
    localparam int TSE_VALUE_BITS  = 32;

    // fixed field widths
    localparam int LEN_BITS   = 11;
    localparam int INDEX_BITS = 10;
    localparam int ITEM_BITS  = 32;
    localparam int POS_BITS   = 10;

    // action codes
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    // search sequencer states
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DIV   = 5'b00010,
        ST_PROBE = 5'b00100,
        ST_CMP   = 5'b01000,
        ST_FIN   = 5'b10000
    } state_t;

endpackage

@@ rtl/tse_if.sv @@
// valid/ready channel interfaces for request, result and config transactions
interface tse_req_if
    import tse_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [INDEX_BITS-1:0]       entry_index;
    logic signed [ITEM_BITS-1:0] item_value;

    modport source (output valid, output action, output entry_index, output item_value,
                    input ready);
    modport sink   (input valid, input action, input entry_index, input item_value,
                    output ready);
endinterface

interface tse_rsp_if
    import tse_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                found;
    logic [POS_BITS-1:0] found_position;

    modport source (output valid, output found, output found_position, input ready);
    modport sink   (input valid, input found, input found_position, output ready);
endinterface

interface tse_cfg_if
    import tse_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [LEN_BITS-1:0] active_length;

    modport source (output valid, output active_length, input ready);
    modport sink   (input valid, input active_length, output ready);
endinterface

@@ rtl/tse_ram.sv @@
// generic ram, one write port and two registered read ports
module tse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr_a,
    output logic [WIDTH-1:0] rd_data_a,
    input  logic [AW-1:0]    rd_addr_b,
    output logic [WIDTH-1:0] rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

@@ rtl/ternary_search_engine_core.sv @@
// ternary search engine top level: sorted store in ram and a probe sequencer
// write transaction: stored when accepted, no result
// search transaction: each probe round runs ST_DIV (multiply for the third), ST_PROBE
//   (ram read) and ST_CMP (compare), about log3(active_length)+1 rounds, then ST_FIN
//   posts the result once the output slot is free; one search in flight at a time
// reset: sequencer idle, active_length 0, no result pending; store contents undefined
module ternary_search_engine_core
    import tse_pkg::*;
#(
    parameter int STORE_DEPTH = TSE_STORE_DEPTH,
    parameter int VALUE_BITS  = TSE_VALUE_BITS
)(
    input logic      clk,
    input logic      rst_n,
    tse_cfg_if.sink  cfg,
    tse_req_if.sink  req,
    tse_rsp_if.source rsp
);

    // index, bound and length widths
    localparam int IDX_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int BND_W  = IDX_W + 2;
    localparam int LEN_W  = (IDX_W + 1 > LEN_BITS) ? IDX_W + 1 : LEN_BITS;
    // divide by three as multiply by a rounded-up reciprocal; error stays below 1/4
    localparam int SHIFT  = 2 * IDX_W + 2;
    localparam int PROD_W = IDX_W + SHIFT;
    localparam logic [SHIFT-1:0] RECIP = SHIFT'(((64'd1 << SHIFT) / 64'd3) + 64'd1);
    localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(STORE_DEPTH);

    // sign-extend the 32-bit field, then keep the store width
    function automatic logic signed [VALUE_BITS-1:0] norm_value(
        input logic signed [ITEM_BITS-1:0] v
    );
        logic signed [63:0] wide;
        wide = 64'(v);
        return wide[VALUE_BITS-1:0];
    endfunction

    // control state
    state_t               state_reg, state_next;
    logic [LEN_BITS-1:0]  active_len_reg;
    logic                 rsp_valid_reg, rsp_valid_next;

    // datapath registers
    logic signed [VALUE_BITS-1:0] key_reg, key_next;
    logic signed [BND_W-1:0]      low_reg, low_next;
    logic signed [BND_W-1:0]      high_reg, high_next;
    logic [PROD_W-1:0]            prod_reg, prod_next;
    logic [IDX_W-1:0]             m1_reg, m1_next;
    logic [IDX_W-1:0]             m2_reg, m2_next;
    logic                         res_found_reg, res_found_next;
    logic [POS_BITS-1:0]          res_pos_reg, res_pos_next;
    logic                         rsp_found_reg, rsp_found_next;
    logic [POS_BITS-1:0]          rsp_pos_reg, rsp_pos_next;

    // ram ports
    logic                         wr_en;
    logic [IDX_W-1:0]             wr_addr;
    logic [VALUE_BITS-1:0]        wr_data;
    logic [IDX_W-1:0]             rd_addr_a, rd_addr_b;
    logic [VALUE_BITS-1:0]        rd_data_a, rd_data_b;

    // helpers
    logic                         req_fire;
    logic [LEN_W-1:0]             len_raw, len_sat, idx_ext;
    logic signed [BND_W-1:0]      span;
    logic [IDX_W-1:0]             third, m1_c, m2_c;
    logic signed [VALUE_BITS-1:0] probe_a, probe_b;
    logic signed [BND_W-1:0]      m1_b, m2_b;
    logic signed [BND_W-1:0]      cmp_low, cmp_high;
    logic                         slot_free;

    // config port is always ready; the length is sampled only when a search starts
    assign cfg.ready = 1'b1;

    // one search at a time; writes also wait for the sequencer
    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid & req.ready;

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.found          = rsp_found_reg;
    assign rsp.found_position = rsp_pos_reg;

    // output slot can take a new result when empty or being drained
    assign slot_free = ~rsp_valid_reg | rsp.ready;

    // active length saturates at the store depth
    assign len_raw = LEN_W'(active_len_reg);
    assign len_sat = (len_raw > DEPTH_LEN) ? DEPTH_LEN : len_raw;

    // write path, out-of-range indices dropped
    assign idx_ext = LEN_W'(req.entry_index);
    assign wr_en   = req_fire & (req.action == ACT_WRITE) & (idx_ext < DEPTH_LEN);
    assign wr_addr = idx_ext[IDX_W-1:0];
    assign wr_data = norm_value(req.item_value);

    // probe points: bounds are inside [0, len-1] whenever a round runs
    assign span  = high_reg - low_reg;
    assign third = prod_reg[SHIFT +: IDX_W];
    assign m1_c  = low_reg[IDX_W-1:0] + third;
    assign m2_c  = high_reg[IDX_W-1:0] - third;

    // ram read issued in the probe state, data back for the compare state
    assign rd_addr_a = m1_c;
    assign rd_addr_b = m2_c;
    assign probe_a   = rd_data_a;
    assign probe_b   = rd_data_b;

    assign m1_b = BND_W'(m1_reg);
    assign m2_b = BND_W'(m2_reg);

    // narrowing of the bounds when neither probe hits
    always_comb
    begin
        cmp_low  = low_reg;
        cmp_high = high_reg;
        if (key_reg < probe_a)
        begin
            cmp_high = m1_b - BND_W'(1);
        end
        else if (probe_b < key_reg)
        begin
            cmp_low = m2_b + BND_W'(1);
        end
        else
        begin
            cmp_low  = m1_b + BND_W'(1);
            cmp_high = m2_b - BND_W'(1);
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        key_next       = key_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        prod_next      = prod_reg;
        m1_next        = m1_reg;
        m2_next        = m2_reg;
        res_found_next = res_found_reg;
        res_pos_next   = res_pos_reg;
        rsp_valid_next = rsp_valid_reg & ~rsp.ready;
        rsp_found_next = rsp_found_reg;
        rsp_pos_next   = rsp_pos_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && req.action == ACT_SEARCH)
                begin
                    key_next = norm_value(req.item_value);
                    low_next = '0;
                    high_next = BND_W'(len_sat - LEN_W'(1));
                    if (len_sat == '0)
                    begin
                        // empty range, nothing to probe
                        res_found_next = 1'b0;
                        res_pos_next   = '0;
                        state_next     = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                // span times reciprocal, registered before use
                prod_next  = PROD_W'(span[IDX_W-1:0]) * PROD_W'(RECIP);
                state_next = ST_PROBE;
            end
            ST_PROBE:
            begin
                m1_next    = m1_c;
                m2_next    = m2_c;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (probe_a == key_reg)
                begin
                    res_found_next = 1'b1;
                    res_pos_next   = POS_BITS'(m1_reg);
                    state_next     = ST_FIN;
                end
                else if (probe_b == key_reg)
                begin
                    res_found_next = 1'b1;
                    res_pos_next   = POS_BITS'(m2_reg);
                    state_next     = ST_FIN;
                end
                else
                begin
                    low_next  = cmp_low;
                    high_next = cmp_high;
                    if (cmp_low > cmp_high)
                    begin
                        // low passed high: not found
                        res_found_next = 1'b0;
                        res_pos_next   = '0;
                        state_next     = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_FIN:
            begin
                // post the result once the output slot frees up
                if (slot_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_found_next = res_found_reg;
                    rsp_pos_next   = res_pos_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            active_len_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                active_len_reg <= cfg.active_length;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        low_reg       <= low_next;
        high_reg      <= high_next;
        prod_reg      <= prod_next;
        m1_reg        <= m1_next;
        m2_reg        <= m2_next;
        res_found_reg <= res_found_next;
        res_pos_reg   <= res_pos_next;
        rsp_found_reg <= rsp_found_next;
        rsp_pos_reg   <= rsp_pos_next;
    end

    // sorted store
    tse_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (STORE_DEPTH),
        .AW    (IDX_W)
    ) u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_data_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd_data_b)
    );

endmodule

@@ rtl/tse_checker.sv @@
// port-level checker for the ternary search engine and its bind
module tse_checker
    import tse_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                req_action,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic                rsp_found,
    input logic [POS_BITS-1:0] rsp_found_position
);

    // searches accepted but not yet delivered
    logic [2:0] pending_reg, pending_next;
    logic       search_in, rsp_out;

    assign search_in = req_valid & req_ready & (req_action == ACT_SEARCH);
    assign rsp_out   = rsp_valid & rsp_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (search_in && !rsp_out)
        begin
            pending_next = pending_reg + 3'd1;
        end
        else if (!search_in && rsp_out)
        begin
            pending_next = pending_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found)
            && $stable(rsp_found_position))
        else $error("result changed while stalled");

    // a miss reports position zero
    a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_found |-> rsp_found_position == '0)
        else $error("not-found result with nonzero position");

    // no result without an outstanding search
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pending_reg != 3'd0)
        else $error("result without a search");

    // at most one search in work plus one result waiting
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd2)
        else $error("too many searches outstanding");

endmodule

bind ternary_search_engine_core tse_checker u_tse_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .req_action         (req.action),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_found          (rsp.found),
    .rsp_found_position (rsp.found_position)
);

@@ sim/ternary_search_engine_core_tb.sv @@
// self-checking testbench for the ternary search engine core
`timescale 1ns / 100ps

module ternary_search_engine_core_tb;
    import tse_pkg::*;

    // quiet cycles tolerated before the run is declared hung
    localparam int QUIET_LIMIT   = 3000;
    // idle time after the last result before a register write or the end
    localparam int SETTLE_CYCLES = 40;
    // length of the deliberate result hold-off
    localparam int HOLD_CYCLES   = 400;
    // random items wanted beyond the bulk store fills
    localparam int RANDOM_ITEMS  = 750;

    localparam logic signed [ITEM_BITS-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [ITEM_BITS-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic                found;
        logic [POS_BITS-1:0] position;
    } search_result_t;

    // shadow store plus the queue of search outcomes not yet returned
    class search_scoreboard;
        logic signed [ITEM_BITS-1:0] entries [TSE_STORE_DEPTH];
        bit                          written [TSE_STORE_DEPTH];
        int unsigned                 length;
        int                          mismatches;
        search_result_t              outcomes [$];

        function new();
            foreach (entries[i])
            begin
                entries[i] = '0;
                written[i] = 1'b0;
            end
            length     = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return outcomes.size();
        endfunction

        function bit all_written(int count);
            for (int i = 0; i < count; i++)
                if (!written[i])
                    return 1'b0;
            return 1'b1;
        endfunction

        // two probes per round, a third in from each bound
        function search_result_t locate_key(logic signed [ITEM_BITS-1:0] key);
            search_result_t res;
            int             lo;
            int             hi;
            int             third;
            int             p1;
            int             p2;
            res.found    = 1'b0;
            res.position = '0;
            lo = 0;
            hi = ((length > TSE_STORE_DEPTH) ? TSE_STORE_DEPTH : int'(length)) - 1;
            while (lo <= hi)
            begin
                third = (hi - lo) / 3;
                p1    = lo + third;
                p2    = hi - third;
                if (entries[p1] == key)
                begin
                    res.found    = 1'b1;
                    res.position = POS_BITS'(p1);
                    return res;
                end
                if (entries[p2] == key)
                begin
                    res.found    = 1'b1;
                    res.position = POS_BITS'(p2);
                    return res;
                end
                if (key < entries[p1])
                    hi = p1 - 1;
                else if (entries[p2] < key)
                    lo = p2 + 1;
                else
                begin
                    lo = p1 + 1;
                    hi = p2 - 1;
                end
            end
            return res;
        endfunction

        function void note_request(logic action, logic [INDEX_BITS-1:0] index,
                                   logic signed [ITEM_BITS-1:0] value);
            if (action == ACT_WRITE)
            begin
                entries[index] = value;
                written[index] = 1'b1;
            end
            else
                outcomes.push_back(locate_key(value));
        endfunction

        function void check_result(logic found, logic [POS_BITS-1:0] position);
            search_result_t want;
            if (outcomes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: found=%0b position=%0d", found, position);
                return;
            end
            want = outcomes.pop_front();
            if (want.found !== found || want.position !== position)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected found=%0b position=%0d, got found=%0b position=%0d",
                             want.found, want.position, found, position);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    tse_cfg_if cfg_ch();
    tse_req_if req_ch();
    tse_rsp_if rsp_ch();

    ternary_search_engine_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    search_scoreboard sb;

    int items_sent;     // every request transaction accepted
    int bulk_writes;    // writes spent in store fills of more than 300 entries
    int burst_left;     // requests left in the current sender burst
    bit req_held;       // request valid currently driven high
    bit hold_rsp;       // asks the receiver for one long hold-off
    int quiet_cycles;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // watchdog: any transaction on any channel resets the quiet count
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side: check each accepted transaction, then pick next ready
    initial
    begin
        int mode;
        int mode_left;
        int hold_left;
        int cycle_count;
        bit take;
        mode        = 0;
        mode_left   = 0;
        hold_left   = 0;
        cycle_count = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
                sb.check_result(rsp_ch.found, rsp_ch.found_position);
            if (hold_rsp)
            begin
                hold_left = HOLD_CYCLES;
                hold_rsp  = 1'b0;
            end
            // stall pattern is picked anew when the current one runs out
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(40, 200);
            end
            else
                mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                take = 1'b0;
            end
            else
            begin
                case (mode)
                    0:       take = 1'b1;
                    1:       take = 1'($urandom_range(0, 1));
                    2:       take = (cycle_count % 4 == 0);
                    default: take = ($urandom_range(0, 9) != 0);
                endcase
            end
            rsp_ch.ready <= take;
        end
    end

    // one request transaction, then maybe a gap before the next burst
    task automatic send_request(input logic action, input logic [INDEX_BITS-1:0] index,
                                input logic signed [ITEM_BITS-1:0] value);
        int gap;
        req_ch.valid       <= 1'b1;
        req_ch.action      <= action;
        req_ch.entry_index <= index;
        req_ch.item_value  <= value;
        req_held = 1'b1;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_request(action, index, value);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 4) == 0 ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 12);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                req_held = 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic write_entry(input logic [INDEX_BITS-1:0] index,
                               input logic signed [ITEM_BITS-1:0] value);
        send_request(ACT_WRITE, index, value);
    endtask

    // entry_index carries random bits on a search, the block ignores it
    task automatic search_key(input logic signed [ITEM_BITS-1:0] key);
        send_request(ACT_SEARCH, INDEX_BITS'($urandom_range(0, 1023)), key);
    endtask

    // register write only once the block is drained and quiet
    task automatic set_length(input logic [LEN_BITS-1:0] len);
        if (req_held)
        begin
            req_ch.valid <= 1'b0;
            req_held = 1'b0;
        end
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_ch.valid         <= 1'b1;
        cfg_ch.active_length <= len;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        sb.length = 32'(len);
    endtask

    // fill entries 0..count-1: spread ascending, dense ascending with
    // repeats, or plain random (unsorted)
    task automatic fill_store(input int count, input int style);
        longint                      level;
        int unsigned                 step_max;
        logic signed [ITEM_BITS-1:0] value;
        step_max = (count < 3) ? 32'h7FFF_FFFF : 32'hFFFF_FFFF / count * 2;
        if (style == 1)
        begin
            step_max = 3;
            level    = longint'($signed($urandom));
        end
        else
        begin
            level = -64'sd2147483648;
            if ($urandom_range(0, 1) != 0)
                level += longint'($urandom_range(0, step_max / 2));
        end
        for (int i = 0; i < count; i++)
        begin
            if (style == 2)
                value = $urandom;
            else
            begin
                if (level > 64'sd2147483647)
                    level = 64'sd2147483647;
                value = level[ITEM_BITS-1:0];
                level += longint'($urandom_range(0, step_max));
            end
            write_entry(INDEX_BITS'(i), value);
            if (count > 300)
                bulk_writes++;
        end
    endtask

    // mostly keys that are stored, then near misses, extremes and noise
    function automatic logic signed [ITEM_BITS-1:0] pick_key(int span);
        int                          r;
        logic signed [ITEM_BITS-1:0] stored;
        r = $urandom_range(0, 99);
        if (span > 0)
            stored = sb.entries[$urandom_range(0, span - 1)];
        else
            stored = $urandom;
        if (r < 60)
            return stored;
        if (r < 80)
            return ($urandom_range(0, 1) != 0) ? stored + 1 : stored - 1;
        if (r < 88)
        begin
            case ($urandom_range(0, 2))
                0:       return VALUE_MIN;
                1:       return VALUE_MAX;
                default: return '0;
            endcase
        end
        return $urandom;
    endfunction

    // one setting of active_length with its fill and a run of transactions
    task automatic run_phase(input int phase);
        int unsigned len;
        int          span;
        int          style;
        int          ops;
        int          r;
        bit          refill;
        r = $urandom_range(0, 99);
        // first phases: saturated length, exact full length, hold-off
        if (phase == 0)
            len = 2047;
        else if (phase == 1)
            len = 1024;
        else if (phase == 2)
            len = 20;
        else if (r < 4)
            len = 0;
        else if (r < 9)
            len = $urandom_range(1024, 2047);
        else if (r < 75)
            len = $urandom_range(1, 40);
        else
            len = $urandom_range(41, 300);
        set_length(LEN_BITS'(len));
        span = (len > TSE_STORE_DEPTH) ? TSE_STORE_DEPTH : int'(len);

        r      = $urandom_range(0, 99);
        style  = (phase < 3) ? 0 : (r < 10) ? 2 : (r < 35) ? 1 : 0;
        refill = (phase == 1) ? 1'b0
               : (span > 300) ? ($urandom_range(0, 9) == 0)
               : ($urandom_range(0, 2) != 0);
        // searches never reach an entry that was never written
        if (span > 0 && (refill || !sb.all_written(span)))
            fill_store(span, style);

        // receiver sits on its result while requests keep coming
        if (phase == 2)
            hold_rsp = 1'b1;

        ops = $urandom_range(8, 40);
        for (int k = 0; k < ops; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 12 && span < TSE_STORE_DEPTH)
                write_entry(INDEX_BITS'($urandom_range(span, 1023)), $urandom);
            else if (r < 14 && span > 0 && span <= 300)
                write_entry(INDEX_BITS'($urandom_range(0, span - 1)), $urandom);
            else
                search_key(pick_key(span));
        end
    endtask

    initial
    begin
        int phase;
        sb = new();
        items_sent  = 0;
        bulk_writes = 0;
        burst_left  = 0;
        req_held    = 1'b0;
        hold_rsp    = 1'b0;
        phase       = 0;
        rst_n                <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.action        <= ACT_WRITE;
        req_ch.entry_index   <= '0;
        req_ch.item_value    <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.active_length <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero active length: nothing is probed, never found
        set_length(11'd0);
        search_key(VALUE_MIN);
        search_key(VALUE_MAX);

        // single entry holding the most negative value; top index written
        set_length(11'd1);
        write_entry(10'd0, VALUE_MIN);
        write_entry(10'd1023, VALUE_MAX);
        search_key(VALUE_MIN);
        search_key(VALUE_MAX);
        search_key('0);

        // two entries, largest value in the second
        set_length(11'd2);
        write_entry(10'd1, VALUE_MAX);
        search_key(VALUE_MAX);
        search_key(VALUE_MIN);
        search_key(32'sd5);

        // five entries with a repeated value, a hit and a middle-third miss
        set_length(11'd5);
        write_entry(10'd1, -32'sd100);
        write_entry(10'd2, -32'sd7);
        write_entry(10'd3, '0);
        write_entry(10'd4, '0);
        search_key('0);
        search_key(-32'sd7);
        search_key(-32'sd8);

        // unsorted store: the probe path walks past the stored key
        write_entry(10'd0, 32'sd50);
        search_key(32'sd50);

        while (items_sent - bulk_writes < RANDOM_ITEMS)
        begin
            run_phase(phase);
            phase++;
        end

        if (req_held)
        begin
            req_ch.valid <= 1'b0;
            req_held = 1'b0;
        end
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
